FILE: rtl/core/cursor_text_buffer_defines.svh
// Assertion macros used by the checker file of the cursor text buffer.
`ifndef CURSOR_TEXT_BUFFER_DEFINES_SVH
`define CURSOR_TEXT_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is high.
`define CTB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is high.
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ctb_pkg.sv
`timescale 1ns / 1ps

package ctb_pkg;

  localparam int unsigned CTB_DEPTH_DEFAULT = 1024;
  localparam int unsigned LEN_W = 11;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LEFT   = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_BACK   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EDGE  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctb_state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_in;
    logic [9:0] read_index;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]       char_out;
    logic [LEN_W-1:0] text_length;
    logic [LEN_W-1:0] cursor_position;
    logic [1:0]       status;
  } rsp_item_t;

endpackage

FILE: rtl/core/cursor_text_buffer.sv
`timescale 1ns / 1ps
// Gap-buffer text line with an edit cursor; one result item per command item.
// The result item is registered at the end of the execute state that follows acceptance,
// which is held while the previous result item is still waiting on rsp_ready.
// A new command is not accepted until the execute state has completed, set by the store's
// read-then-write sequence (read at accept, write back in the execute cycle).
// Reset clears the cursor and length counters; the text store is not cleared.
module cursor_text_buffer #(
  parameter int unsigned BUFFER_DEPTH = ctb_pkg::CTB_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ctb_pkg::cmd_item_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ctb_pkg::rsp_item_t rsp
);
  import ctb_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned XW = ((CW > 10) ? CW : 10) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];

  ctb_state_e state, state_next;
  logic [CW-1:0] before_cnt, after;
  logic [CW-1:0] before_cnt_next, after_next;
  logic [CW-1:0] total;

  logic cmd_accept;
  logic exec_done;

  // Work decided at accept and carried into the execute cycle.
  logic          p_we, p_use_mem, p_read_ok;
  logic [AW-1:0] p_waddr;
  logic [7:0]    p_ch;
  status_e       p_status;

  logic          we_c, use_mem_c, read_ok_c;
  logic [AW-1:0] waddr_c, raddr_c;
  status_e       status_c;
  logic [XW-1:0] idx_x;
  logic [7:0]    rd_data;
  logic [7:0]    wdata;

  assign cmd_accept = cmd_valid && cmd_ready;
  assign total      = before_cnt + after;
  assign idx_x      = XW'(cmd.read_index);
  assign wdata      = p_use_mem ? rd_data : p_ch;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_accept) state_next = ST_EXEC;
      ST_EXEC: if (exec_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == ST_IDLE);
    exec_done = (state == ST_EXEC) && (!rsp_valid || rsp_ready);
  end

  // Decode of the accepted item against the current counters.
  always_comb begin
    before_cnt_next = before_cnt;
    after_next      = after;
    status_c        = STAT_DONE;
    we_c            = 1'b0;
    use_mem_c       = 1'b0;
    read_ok_c       = 1'b0;
    waddr_c         = AW'(before_cnt);
    raddr_c         = AW'(before_cnt - CW'(1));
    unique case (cmd.opcode)
      OP_INSERT: begin
        if (total >= DEPTH_C) begin
          status_c = STAT_FULL;
        end else begin
          we_c            = 1'b1;
          waddr_c         = AW'(before_cnt);
          before_cnt_next = before_cnt + CW'(1);
        end
      end
      OP_LEFT: begin
        if (before_cnt == '0) begin
          status_c = STAT_EDGE;
        end else begin
          // The last character before the cursor moves to the bottom of the top half.
          raddr_c         = AW'(before_cnt - CW'(1));
          waddr_c         = AW'(DEPTH_C - after - CW'(1));
          we_c            = 1'b1;
          use_mem_c       = 1'b1;
          before_cnt_next = before_cnt - CW'(1);
          after_next      = after + CW'(1);
        end
      end
      OP_RIGHT: begin
        if (after == '0) begin
          status_c = STAT_EDGE;
        end else begin
          raddr_c         = AW'(DEPTH_C - after);
          waddr_c         = AW'(before_cnt);
          we_c            = 1'b1;
          use_mem_c       = 1'b1;
          before_cnt_next = before_cnt + CW'(1);
          after_next      = after - CW'(1);
        end
      end
      OP_BACK: begin
        if (before_cnt == '0) begin
          status_c = STAT_EDGE;
        end else begin
          before_cnt_next = before_cnt - CW'(1);
        end
      end
      OP_READ: begin
        if (idx_x >= XW'(total)) begin
          status_c = STAT_RANGE;
        end else if (idx_x < XW'(before_cnt)) begin
          raddr_c   = AW'(idx_x);
          read_ok_c = 1'b1;
        end else begin
          // Skip over the gap into the top half.
          raddr_c   = AW'(idx_x + XW'(DEPTH_C) - XW'(total));
          read_ok_c = 1'b1;
        end
      end
      default: status_c = STAT_EDGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      before_cnt <= '0;
      after      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_accept) begin
        before_cnt <= before_cnt_next;
        after      <= after_next;
      end
      if (exec_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      p_we      <= we_c;
      p_use_mem <= use_mem_c;
      p_read_ok <= read_ok_c;
      p_waddr   <= waddr_c;
      p_ch      <= cmd.char_in;
      p_status  <= status_c;
    end
    if (exec_done) begin
      rsp.char_out        <= p_read_ok ? rd_data : 8'd0;
      rsp.text_length     <= LEN_W'(total);
      rsp.cursor_position <= LEN_W'(before_cnt);
      rsp.status          <= p_status;
    end
  end

  // Text store: read at accept, written back once the execute cycle completes.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      rd_data <= mem[raddr_c];
    end
    if (exec_done && p_we) begin
      mem[p_waddr] <= wdata;
    end
  end

endmodule

FILE: rtl/core/ctb_checker.sv
`timescale 1ns / 1ps
`include "cursor_text_buffer_defines.svh"

module ctb_checker #(
  parameter int unsigned BUFFER_DEPTH = ctb_pkg::CTB_DEPTH_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input ctb_pkg::rsp_item_t rsp
);
  import ctb_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(BUFFER_DEPTH);

  logic cmd_take;
  logic rsp_held;

  assign cmd_take = cmd_valid && cmd_ready;
  assign rsp_held = rsp_valid && !rsp_ready;

  `CTB_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_take, !cmd_ready,
    "ready high right after an accepted item")
  `CTB_ASSERT_SAME(a_full_length, clk, rst, rsp_valid && (rsp.status == STAT_FULL),
    rsp.text_length == DEPTH_L, "buffer-full status with text shorter than the store")
  `CTB_ASSERT_SAME(a_char_only_when_done, clk, rst, rsp_valid && (rsp.char_out != 8'd0),
    rsp.status == STAT_DONE, "nonzero character on a failed item")
  `CTB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_held, rsp_valid && $stable(rsp),
    "stalled result item changed")

endmodule

bind cursor_text_buffer ctb_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctb_checker (.*);
